@@ hdl/tbc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbc_pkg: task barrier collector shared definitions
// Sizes, status codes and the result item packing.
// ----------------------------------------------------------------------------
package tbc_pkg;

  localparam int MAX_TASKS = 64;
  localparam int SLOT_W    = $clog2(MAX_TASKS);
  localparam int SIZE_W    = $clog2(MAX_TASKS + 1);

  localparam int IN_DATA_W  = 80;
  localparam int OUT_DATA_W = 64;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_DUP      = 3'd1,
    ST_ZERO     = 3'd2,
    ST_MISMATCH = 3'd3,
    ST_RANGE    = 3'd4,
    ST_OVER     = 3'd5
  } status_t;

  // tdata: status[2:0], dest_rank[8:3], dest_port[24:9], dest_host[56:25]
  function automatic logic [OUT_DATA_W-1:0] pack_out(
    input status_t     status,
    input logic [5:0]  rank,
    input logic [15:0] port,
    input logic [31:0] host
  );
    logic [OUT_DATA_W-1:0] d;
    d = '0;
    d[2:0]   = status;
    d[8:3]   = rank;
    d[24:9]  = port;
    d[56:25] = host;
    return d;
  endfunction

endpackage

@@ hdl/task_barrier_collector_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// task_barrier_collector_unit: barrier arrival collector
// Counts task arrivals per round and releases the whole group in rank order.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one arrival item per handshake (rank, group size, port, host).
//   out_* : result items. An arrival that does not complete the round gives
//           one item (tuser 0, tlast 1) carrying its status. The arrival that
//           completes the round gives one release item per task (tuser 1),
//           ranks 0 upward, tlast on the final one.
//   An arrival is a read-modify-write of its slot in the slot memory: the
//   port/host read is registered, and the result is loaded into the output
//   register in the decide state once that register is free. Each release
//   item goes through a slot memory read, then an output load. in_tready is
//   high only while the sequencer is idle.
//   Reset clears the round size, the arrival count, the slot valid bits and
//   the output valid; no clearing pass is needed.
//   While the receiver stalls, the current result holds in the output
//   register and the sequencer waits for it to be taken.
// ----------------------------------------------------------------------------
module task_barrier_collector_unit
  import tbc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // task_rank[15:0], group_size[31:16], reply_port[47:32], host_id[79:48]
  input  logic [IN_DATA_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // status[2:0], dest_rank[8:3], dest_port[24:9], dest_host[56:25], zero fill
  output logic [OUT_DATA_W-1:0] out_tdata,
  // release_res[0]
  output logic                  out_tuser,
  output logic                  out_tlast
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DECIDE,
    S_REL_RD,
    S_REL_OUT
  } state_t;

  state_t                state_r, state_nxt;
  logic [15:0]           rank_r, rank_nxt;
  logic [15:0]           size_r, size_nxt;
  logic [15:0]           port_r, port_nxt;
  logic [31:0]           host_r, host_nxt;
  logic [SIZE_W-1:0]     round_size_r, round_size_nxt;
  logic [SIZE_W-1:0]     arrived_r, arrived_nxt;
  logic [MAX_TASKS-1:0]  written_r, written_nxt;
  logic [SLOT_W-1:0]     idx_r, idx_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;
  logic                  out_user_r, out_user_nxt;
  logic                  out_last_r, out_last_nxt;

  logic [47:0]           slot_mem [0:MAX_TASKS-1];
  logic [47:0]           rd_data_r;
  logic [SLOT_W-1:0]     rd_addr;
  logic                  mem_we;
  logic                  out_free;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;
  assign out_free   = !out_valid_r || out_tready;

  always_comb begin
    logic              opening;
    logic [SIZE_W-1:0] eff_size;
    logic [SIZE_W-1:0] cnt;
    logic              hit;
    logic              rel_last;
    logic [15:0]       rel_port;
    logic [31:0]       rel_host;
    status_t           st;

    state_nxt      = state_r;
    rank_nxt       = rank_r;
    size_nxt       = size_r;
    port_nxt       = port_r;
    host_nxt       = host_r;
    round_size_nxt = round_size_r;
    arrived_nxt    = arrived_r;
    written_nxt    = written_r;
    idx_nxt        = idx_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_data_nxt   = out_data_r;
    out_user_nxt   = out_user_r;
    out_last_nxt   = out_last_r;
    mem_we         = 1'b0;
    rd_addr        = rank_r[SLOT_W-1:0];

    opening  = (round_size_r == '0);
    eff_size = opening ? size_r[SIZE_W-1:0] : round_size_r;
    cnt      = arrived_r;
    hit      = 1'b0;
    st       = ST_OK;
    rel_last = ({1'b0, idx_r} + SIZE_W'(1)) == round_size_r;
    rel_port = written_r[idx_r] ? rd_data_r[47:32] : 16'd0;
    rel_host = written_r[idx_r] ? rd_data_r[31:0]  : 32'd0;

    unique case (state_r)
      S_IDLE: begin
        rd_addr = in_tdata[SLOT_W-1:0];
        if (in_tvalid) begin
          rank_nxt  = in_tdata[15:0];
          size_nxt  = in_tdata[31:16];
          port_nxt  = in_tdata[47:32];
          host_nxt  = in_tdata[79:48];
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (out_free) begin
          if (size_r == 16'd0) begin
            st = ST_ZERO;
          end else if (opening && size_r > 16'(MAX_TASKS)) begin
            st = ST_OVER;
          end else if (!opening && size_r != 16'(round_size_r)) begin
            st = ST_MISMATCH;
          end else begin
            if (opening) begin
              round_size_nxt = size_r[SIZE_W-1:0];
              arrived_nxt    = '0;
              written_nxt    = '0;
              cnt            = '0;
            end
            if (rank_r >= 16'(eff_size)) begin
              st = ST_RANGE;
            end else begin
              hit = !opening && written_r[rank_r[SLOT_W-1:0]] && (rd_data_r[47:32] != 16'd0);
              if (hit) begin
                st = ST_DUP;
              end else begin
                cnt = cnt + SIZE_W'(1);
              end
              arrived_nxt                       = cnt;
              written_nxt[rank_r[SLOT_W-1:0]]   = 1'b1;
              mem_we                            = 1'b1;
            end
          end
          if (st != ST_RANGE && st != ST_ZERO && st != ST_OVER && st != ST_MISMATCH
              && cnt == eff_size) begin
            idx_nxt   = '0;
            state_nxt = S_REL_RD;
          end else begin
            out_valid_nxt = 1'b1;
            out_data_nxt  = pack_out(st, 6'd0, 16'd0, 32'd0);
            out_user_nxt  = 1'b0;
            out_last_nxt  = 1'b1;
            state_nxt     = S_IDLE;
          end
        end
      end
      S_REL_RD: begin
        rd_addr   = idx_r;
        state_nxt = S_REL_OUT;
      end
      S_REL_OUT: begin
        rd_addr = idx_r;
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = pack_out(ST_OK, 6'(idx_r), rel_port, rel_host);
          out_user_nxt  = 1'b1;
          out_last_nxt  = rel_last;
          if (rel_last) begin
            round_size_nxt = '0;
            arrived_nxt    = '0;
            written_nxt    = '0;
            state_nxt      = S_IDLE;
          end else begin
            idx_nxt   = idx_r + SLOT_W'(1);
            state_nxt = S_REL_RD;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      round_size_r <= '0;
      arrived_r    <= '0;
      written_r    <= '0;
      idx_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      round_size_r <= round_size_nxt;
      arrived_r    <= arrived_nxt;
      written_r    <= written_nxt;
      idx_r        <= idx_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    rank_r     <= rank_nxt;
    size_r     <= size_nxt;
    port_r     <= port_nxt;
    host_r     <= host_nxt;
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
    out_last_r <= out_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      slot_mem[rank_r[SLOT_W-1:0]] <= {port_r, host_r};
    end
    rd_data_r <= slot_mem[rd_addr];
  end

endmodule

@@ hdl/tbc_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbc_checker: port-level checks for the barrier collector
// Watches the ports of the top level; bound to it below.
// ----------------------------------------------------------------------------
module tbc_checker
  import tbc_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic                  out_tuser,
  input logic                  out_tlast
);

  // one item in flight: input busy right after an accept
  a_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input ready right after an accepted item");

  // stalled item holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
      && $stable(out_tuser) && $stable(out_tlast))
    else $error("stalled result item changed");

  // status items stand alone
  a_ack_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tlast && out_tdata[56:3] == '0)
    else $error("status item with release fields or without last");

  // releases always carry an accepted status
  a_rel_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[2:0] == ST_OK)
    else $error("release item with nonzero status");

  // a release burst starts at rank 0
  a_rel_first: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tlast ##1 out_tvalid && out_tuser
      |-> out_tdata[8:3] == 6'd0)
    else $error("release burst not starting at rank zero");

endmodule

bind task_barrier_collector_unit tbc_checker u_tbc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
